>>> hdl/assert_macros.svh
// Assertion macros shared by the timer heap RTL.
// No dependencies; the including module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/tdmh_pkg.sv
// Package for the timer deadline min-heap: payload structs, codes, FSM states.
// No dependencies.
`default_nettype none

package tdmh_pkg;

  localparam int unsigned TimerCountDef = 64;
  localparam int unsigned TimeWidthDef  = 64;

  // Action codes
  localparam logic [1:0] ACT_ACTIVATE   = 2'd0;
  localparam logic [1:0] ACT_DEACTIVATE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP     = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_REDUNDANT = 2'd1;
  localparam logic [1:0] STS_FULL     = 2'd2;
  localparam logic [1:0] STS_INACTIVE = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         timer_id;
    logic signed [63:0] deadline;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               timer_active;
    logic signed [63:0] timer_deadline;
    logic               min_valid;
    logic [5:0]         min_timer;
    logic signed [63:0] min_deadline;
    logic [6:0]         active_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LAST_WAIT,
    ST_DN_RD,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POS_RD,
    ST_HEAP_RD,
    ST_HEAP_WAIT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> hdl/timer_deadline_min_heap.sv
// Timer deadline min-heap: indexed binary heap with position map and sequencer.
// Depends on tdmh_pkg and assert_macros.svh.
//
// One item is handled at a time. After the input transfer the sequencer walks
// the heap one level per step (registered memory read, then compare and
// write). Activate sifts up from the new last slot; deactivate sifts down then
// up from the freed slot; lookup reads the position map, then the heap. The
// input is stalled until the result is in the output register; a waiting
// result does not block the next transfer.
`default_nettype none

module timer_deadline_min_heap #(
  parameter int unsigned TIMER_COUNT = tdmh_pkg::TimerCountDef,
  parameter int unsigned TIME_WIDTH  = tdmh_pkg::TimeWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tdmh_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tdmh_pkg::out_item_t      out_data_o
);
  import tdmh_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned SW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned CW = $clog2(TIMER_COUNT + 1);
  localparam int unsigned TW = TIME_WIDTH;

  // Memories
  logic signed [TW-1:0] heap_dl_mem  [TIMER_COUNT];
  logic [SW-1:0]        heap_own_mem [TIMER_COUNT];
  logic [SW-1:0]        pos_mem      [TIMER_COUNT];

  logic                 heap_we;
  logic [SW-1:0]        heap_waddr, hra_addr, hrb_addr;
  logic signed [TW-1:0] heap_wdl;
  logic [SW-1:0]        heap_wown;
  logic signed [TW-1:0] hra_dl_q, hrb_dl_q;
  logic [SW-1:0]        hra_own_q, hrb_own_q;

  logic                 pos_we;
  logic [SW-1:0]        pos_waddr, pos_wdata, pos_raddr, pos_rdata_q;

  // Control and work registers
  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [SW-1:0]        at_q, at_d, at0_q, at0_d;
  logic signed [TW-1:0] ent_dl_q, ent_dl_d, rise_dl_q, rise_dl_d;
  logic [SW-1:0]        ent_own_q, ent_own_d, rise_own_q, rise_own_d;
  logic [1:0]           op_q, status_q, status_d;
  logic [SW-1:0]        idx_q;
  logic                 known_q;
  logic                 act_q, act_d;
  logic signed [TW-1:0] tdl_q, tdl_d;
  logic [TIMER_COUNT-1:0] live_q;
  logic                 live_set, live_clr;
  logic signed [TW-1:0] min_dl_q;
  logic [SW-1:0]        min_own_q;
  logic                 out_valid_q, out_load;
  out_item_t            out_q;

  logic                 accept, cur_live;
  logic [CW:0]          c1w, c2w;
  logic [SW-1:0]        c1, c2, parent, best_own;
  logic signed [TW-1:0] best_dl;
  logic                 move;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cur_live   = known_q && live_q[idx_q];

  // Child and parent slot indexes of the current slot
  assign c1w    = (CW + 1)'({at_q, 1'b1});
  assign c2w    = c1w + 1'b1;
  assign c1     = SW'(c1w);
  assign c2     = SW'(c2w);
  assign parent = SW'((at_q - 1'b1) >> 1);

  // Sift-down compare: smallest of entry and existing children, left first
  always_comb begin
    best_dl  = ent_dl_q;
    best_own = ent_own_q;
    move     = 1'b0;
    if (c1w < (CW + 1)'(cnt_q) && best_dl > hra_dl_q) begin
      best_dl  = hra_dl_q;
      best_own = hra_own_q;
      move     = 1'b1;
    end
    if (c2w < (CW + 1)'(cnt_q) && best_dl > hrb_dl_q) begin
      best_dl  = hrb_dl_q;
      best_own = hrb_own_q;
      move     = 1'b1;
    end
  end

  // Sequencer: next state and memory controls
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    at_d       = at_q;
    at0_d      = at0_q;
    ent_dl_d   = ent_dl_q;
    ent_own_d  = ent_own_q;
    rise_dl_d  = rise_dl_q;
    rise_own_d = rise_own_q;
    status_d   = status_q;
    act_d      = act_q;
    tdl_d      = tdl_q;
    live_set   = 1'b0;
    live_clr   = 1'b0;
    heap_we    = 1'b0;
    heap_waddr = at_q;
    heap_wdl   = ent_dl_q;
    heap_wown  = ent_own_q;
    hra_addr   = at_q;
    hrb_addr   = c2;
    pos_we     = 1'b0;
    pos_waddr  = ent_own_q;
    pos_wdata  = at_q;
    pos_raddr  = idx_q;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pos_raddr = SW'(in_data_i.timer_id);
        if (accept) begin
          state_d  = ST_DISPATCH;
          status_d = STS_OK;
          ent_dl_d = $signed(in_data_i.deadline[TW-1:0]);
        end
      end
      ST_DISPATCH: begin
        state_d = ST_POS_RD;
        unique case (op_q)
          ACT_ACTIVATE: begin
            if (cur_live) begin
              status_d = STS_REDUNDANT;
            end else if (!known_q || cnt_q == CW'(TIMER_COUNT)) begin
              status_d = STS_FULL;
            end else begin
              live_set  = 1'b1;
              cnt_d     = cnt_q + 1'b1;
              at_d      = SW'(cnt_q);
              ent_own_d = idx_q;
              state_d   = ST_UP_RD;
            end
          end
          ACT_DEACTIVATE: begin
            if (!cur_live) begin
              status_d = STS_REDUNDANT;
            end else begin
              live_clr = 1'b1;
              cnt_d    = cnt_q - 1'b1;
              if (CW'(pos_rdata_q) < cnt_q - 1'b1) begin
                hra_addr = SW'(cnt_q - 1'b1);
                at_d     = pos_rdata_q;
                at0_d    = pos_rdata_q;
                state_d  = ST_LAST_WAIT;
              end
            end
          end
          default: begin
            if (!cur_live) status_d = STS_INACTIVE;
          end
        endcase
      end
      ST_LAST_WAIT: begin
        ent_dl_d  = hra_dl_q;
        ent_own_d = hra_own_q;
        state_d   = ST_DN_RD;
      end
      ST_DN_RD: begin
        hra_addr = c1;
        hrb_addr = c2;
        state_d  = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (move) begin
          heap_wdl  = best_dl;
          heap_wown = best_own;
          pos_waddr = best_own;
          if (at_q == at0_q) begin
            rise_dl_d  = best_dl;
            rise_own_d = best_own;
          end
          at_d    = (best_own == hra_own_q && c1w < (CW + 1)'(cnt_q)
                     && best_dl == hra_dl_q && !(c2w < (CW + 1)'(cnt_q)
                     && best_dl == hrb_dl_q && best_own == hrb_own_q)) ? c1 :
                    ((best_own == hrb_own_q && best_dl == hrb_dl_q) ? c2 : c1);
          state_d = ST_DN_RD;
        end else begin
          at_d = at0_q;
          if (at_q != at0_q) begin
            ent_dl_d  = rise_dl_q;
            ent_own_d = rise_own_q;
          end
          state_d = ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        hra_addr = parent;
        if (at_q == '0) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
          state_d = ST_POS_RD;
        end else begin
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (ent_dl_q > hra_dl_q) begin
          state_d = ST_POS_RD;
        end else begin
          heap_wdl  = hra_dl_q;
          heap_wown = hra_own_q;
          pos_waddr = hra_own_q;
          at_d      = parent;
          state_d   = ST_UP_RD;
        end
      end
      ST_POS_RD: begin
        act_d = cur_live;
        tdl_d = '0;
        state_d = cur_live ? ST_HEAP_RD : ST_DONE;
      end
      ST_HEAP_RD: begin
        hra_addr = pos_rdata_q;
        state_d  = ST_HEAP_WAIT;
      end
      ST_HEAP_WAIT: begin
        tdl_d   = hra_dl_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_dl_mem[heap_waddr]  <= heap_wdl;
      heap_own_mem[heap_waddr] <= heap_wown;
    end
    hra_dl_q  <= heap_dl_mem[hra_addr];
    hra_own_q <= heap_own_mem[hra_addr];
    hrb_dl_q  <= heap_dl_mem[hrb_addr];
    hrb_own_q <= heap_own_mem[hrb_addr];
  end

  // Position map memory
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rdata_q <= pos_mem[pos_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (live_set) live_q[idx_q] <= 1'b1;
      if (live_clr) live_q[idx_q] <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Work registers and slot-zero shadow
  always_ff @(posedge clk_i) begin
    at_q       <= at_d;
    at0_q      <= at0_d;
    ent_dl_q   <= ent_dl_d;
    ent_own_q  <= ent_own_d;
    rise_dl_q  <= rise_dl_d;
    rise_own_q <= rise_own_d;
    status_q   <= status_d;
    act_q      <= act_d;
    tdl_q      <= tdl_d;
    if (accept) begin
      op_q     <= in_data_i.action;
      idx_q    <= SW'(in_data_i.timer_id);
      known_q  <= (32'(in_data_i.timer_id) < TIMER_COUNT);
    end
    if (heap_we && heap_waddr == '0) begin
      min_dl_q  <= heap_wdl;
      min_own_q <= heap_wown;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.status         <= status_q;
      out_q.timer_active   <= act_q;
      out_q.timer_deadline <= act_q ? 64'(tdl_q) : '0;
      out_q.min_valid      <= (cnt_q != '0);
      out_q.min_timer      <= (cnt_q != '0) ? 6'(min_own_q) : '0;
      out_q.min_deadline   <= (cnt_q != '0) ? 64'(min_dl_q) : '0;
      out_q.active_count   <= 7'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions
  `ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(TIMER_COUNT), "entry count above capacity")
  `ASSERT_IMPLIES(a_live_cnt, state_q == ST_IDLE, $countones(live_q) == 32'(cnt_q),
    "active map disagrees with entry count")
  `ASSERT_IMPLIES(a_heap_wr, heap_we, CW'(heap_waddr) < cnt_q, "heap write beyond count")
  `ASSERT_IMPLIES(a_cnt_chg, cnt_q != $past(cnt_q), $past(state_q) == ST_DISPATCH,
    "entry count changed outside dispatch")

endmodule

`default_nettype wire
